[hw/rtl/wsc_pkg.sv]
// wsc_pkg: shared types and constants of the windowed stereo correlation unit
// depends on nothing; imported by every module of the block

package wsc_pkg;

    // default configuration of the block
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_MAX_WINDOW  = 65536;

    // field and accumulator widths
    localparam int SAMPLE_W  = 16;
    localparam int WIN_W     = 17;
    localparam int SLR_W     = 48;
    localparam int ENERGY_W  = 47;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // back end datapath widths
    localparam int CHUNK_W   = 24;
    localparam int MUL_BW    = 32;
    localparam int PP_W      = CHUNK_W + MUL_BW;
    localparam int PROD_W    = 2 * ENERGY_W;
    localparam int ACC_W     = PROD_W + MUL_BW;
    localparam int Q_W       = 17;
    localparam int U_W       = 16;

    // register map
    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic [WIN_W-1:0] WINDOW_LEN_RESET = 17'd4800;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // sums of one closed window
    typedef struct packed {
        logic signed [SLR_W-1:0] slr;
        logic [ENERGY_W-1:0]     sll;
        logic [ENERGY_W-1:0]     srr;
    } t_sums;

    // back end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_PROD,
        B_RHS,
        B_SQR,
        B_MULT,
        B_CMP,
        B_FIN
    } t_back_state;

endpackage

[hw/rtl/wsc_front.sv]
// wsc_front: sample intake, window counting, product and sum accumulation
// depends on wsc_pkg; hands closed-window sums to the queue

module wsc_front #(
    parameter int SAMPLE_BITS = wsc_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_WINDOW  = wsc_pkg::DEF_MAX_WINDOW
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [wsc_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [wsc_pkg::SAMPLE_W-1:0] i_right_sample,
    input  logic [wsc_pkg::WIN_W-1:0]          i_window_len,
    output logic                              o_push,
    output wsc_pkg::t_sums                    o_sums,
    input  logic                              i_push_ready
);
    import wsc_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int PW    = 2 * SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0] l_s;
    logic signed [SAMPLE_BITS-1:0] r_s;
    logic [WIN_W-1:0]              len_eff;
    logic [CNT_W-1:0]              cnt_inc;
    logic                          close_win;
    logic                          accept;
    logic                          s1_go;

    logic [CNT_W-1:0]              r_cnt;
    logic                          r_s1_valid;
    logic                          r_s1_last;
    logic signed [PW-1:0]          r_p_lr;
    logic [PW-1:0]                 r_p_ll;
    logic [PW-1:0]                 r_p_rr;

    logic signed [SLR_W-1:0]       r_slr;
    logic [ENERGY_W-1:0]           r_sll;
    logic [ENERGY_W-1:0]           r_srr;
    logic signed [SLR_W-1:0]       n_slr;
    logic [ENERGY_W-1:0]           n_sll;
    logic [ENERGY_W-1:0]           n_srr;

    // sample bits in use, sign extended by the signed multiply
    assign l_s = i_left_sample[SAMPLE_BITS-1:0];
    assign r_s = i_right_sample[SAMPLE_BITS-1:0];

    // effective window length
    always_comb begin
        if (i_window_len == '0) begin
            len_eff = WIN_W'(1);
        end else if (i_window_len > WIN_W'(MAX_WINDOW)) begin
            len_eff = WIN_W'(MAX_WINDOW);
        end else begin
            len_eff = i_window_len;
        end
    end

    assign cnt_inc   = r_cnt + CNT_W'(1);
    assign close_win = 32'(cnt_inc) >= 32'(len_eff);

    // stage one drains unless a closing sample meets a full queue
    assign s1_go   = r_s1_valid && !(r_s1_last && !i_push_ready);
    assign o_ready = !r_s1_valid || s1_go;
    assign accept  = i_valid && o_ready;

    // window counter and product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            if (accept) begin
                r_cnt      <= close_win ? '0 : cnt_inc;
                r_s1_valid <= 1'b1;
                r_s1_last  <= close_win;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // squares are formed at full product width, so they never wrap
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_lr <= l_s * r_s;
            r_p_ll <= l_s * l_s;
            r_p_rr <= r_s * r_s;
        end
    end

    // running sums including the product in stage one
    assign n_slr = r_slr + {{(SLR_W - PW){r_p_lr[PW-1]}}, r_p_lr};
    assign n_sll = r_sll + ENERGY_W'(r_p_ll);
    assign n_srr = r_srr + ENERGY_W'(r_p_rr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slr <= '0;
            r_sll <= '0;
            r_srr <= '0;
        end else if (s1_go) begin
            if (r_s1_last) begin
                r_slr <= '0;
                r_sll <= '0;
                r_srr <= '0;
            end else begin
                r_slr <= n_slr;
                r_sll <= n_sll;
                r_srr <= n_srr;
            end
        end
    end

    // closed window goes to the queue
    assign o_push     = s1_go && r_s1_last;
    assign o_sums.slr = n_slr;
    assign o_sums.sll = n_sll;
    assign o_sums.srr = n_srr;

endmodule

[hw/rtl/wsc_queue.sv]
// wsc_queue: short queue of closed-window sums between front and back
// depends on wsc_pkg

module wsc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsc_pkg::t_sums i_sums,
    output logic           o_not_full,
    input  logic           i_pop,
    output logic           o_not_empty,
    output wsc_pkg::t_sums o_sums
);
    import wsc_pkg::*;

    t_sums               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QPTR_W:0]     r_count;
    logic                do_push;
    logic                do_pop;

    assign o_not_full  = r_count != (QPTR_W + 1)'(QDEPTH);
    assign o_not_empty = r_count != '0;
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_sums      = r_mem[r_rptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W + 1)'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_sums;
        end
    end

endmodule

[hw/rtl/wsc_back.sv]
// wsc_back: per-window correlation, round(32768*|sLR|/sqrt(sLL*sRR)) by bit search
// depends on wsc_pkg; one shared 24x32 multiplier accumulated over cycles

module wsc_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_not_empty,
    input  wsc_pkg::t_sums                    i_sums,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [wsc_pkg::SAMPLE_W-1:0] o_correlation
);
    import wsc_pkg::*;

    t_back_state             r_state;
    t_back_state             n_state;

    logic                    r_neg;
    logic [ENERGY_W-1:0]     r_mag;
    logic [ENERGY_W-1:0]     r_sll;
    logic [ENERGY_W-1:0]     r_srr;
    logic [PROD_W-1:0]       r_p;
    logic [PROD_W-1:0]       r_r;
    logic [ACC_W-1:0]        r_acc;
    logic [PP_W-1:0]         r_pp;
    logic [1:0]              r_pp_sh;
    logic [2:0]              r_step;
    logic [3:0]              r_bit;
    logic [Q_W-1:0]          r_q;
    logic [MUL_BW-1:0]       r_t;
    logic                    r_out_valid;
    logic [SAMPLE_W-1:0]     r_out;

    logic [ENERGY_W-1:0]     in_mag;
    logic [Q_W-1:0]          cand;
    logic [U_W-1:0]          u;
    logic [CHUNK_W-1:0]      mul_a;
    logic [MUL_BW-1:0]       mul_b;
    logic [1:0]              mul_sh;
    logic [PP_W-1:0]         mul_p;
    logic [ACC_W-1:0]        pp_ext;
    logic [ACC_W-1:0]        acc_sum;
    logic                    mac_state;
    logic                    mac_last;
    logic                    start;

    // 24-bit slice of a 47-bit operand
    function automatic logic [CHUNK_W-1:0] chunk47(input logic [ENERGY_W-1:0] v,
                                                   input logic sel);
        logic [2*CHUNK_W-1:0] ext;
        ext = (2 * CHUNK_W)'(v);
        return sel ? ext[2*CHUNK_W-1:CHUNK_W] : ext[CHUNK_W-1:0];
    endfunction

    assign in_mag = i_sums.slr[SLR_W-1] ? ENERGY_W'(-i_sums.slr) : ENERGY_W'(i_sums.slr);
    assign cand   = r_q | (Q_W'(1) << r_bit);
    assign u      = U_W'({cand, 1'b0} - (Q_W + 1)'(1));

    // shared multiplier operand selection
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_sh = '0;
        case (r_state)
            B_PROD: begin
                mul_a  = chunk47(r_sll, r_step[1]);
                mul_b  = MUL_BW'(chunk47(r_srr, r_step[0]));
                mul_sh = 2'(r_step[1]) + 2'(r_step[0]);
            end
            B_RHS: begin
                mul_a  = chunk47(r_mag, r_step[1]);
                mul_b  = MUL_BW'(chunk47(r_mag, r_step[0]));
                mul_sh = 2'(r_step[1]) + 2'(r_step[0]);
            end
            B_SQR: begin
                mul_a  = CHUNK_W'(u);
                mul_b  = MUL_BW'(u);
            end
            B_MULT: begin
                case (r_step[1:0])
                    2'd0:    mul_a = r_p[CHUNK_W-1:0];
                    2'd1:    mul_a = r_p[2*CHUNK_W-1:CHUNK_W];
                    2'd2:    mul_a = r_p[3*CHUNK_W-1:2*CHUNK_W];
                    default: mul_a = CHUNK_W'(r_p[PROD_W-1:3*CHUNK_W]);
                endcase
                mul_b  = r_t;
                mul_sh = r_step[1:0];
            end
            default: begin
                mul_a  = '0;
            end
        endcase
    end

    assign mul_p = PP_W'(mul_a) * PP_W'(mul_b);

    // registered partial product placed at its chunk offset
    always_comb begin
        case (r_pp_sh)
            2'd0:    pp_ext = ACC_W'(r_pp);
            2'd1:    pp_ext = ACC_W'({r_pp, {CHUNK_W{1'b0}}});
            2'd2:    pp_ext = ACC_W'({r_pp, {(2 * CHUNK_W){1'b0}}});
            default: pp_ext = {r_pp[ACC_W-3*CHUNK_W-1:0], {(3 * CHUNK_W){1'b0}}};
        endcase
    end

    assign acc_sum   = r_acc + pp_ext;
    assign mac_state = (r_state == B_PROD) || (r_state == B_RHS) || (r_state == B_MULT);
    assign mac_last  = r_step == 3'd4;
    assign start     = (r_state == B_IDLE) && i_not_empty && !r_out_valid;
    assign o_pop     = start;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (start && i_sums.sll != '0 && i_sums.srr != '0) begin
                    n_state = B_PROD;
                end
            end
            B_PROD: begin
                if (mac_last) begin
                    n_state = B_RHS;
                end
            end
            B_RHS: begin
                if (mac_last) begin
                    n_state = B_SQR;
                end
            end
            B_SQR: begin
                if (cand <= Q_W'(32768)) begin
                    n_state = B_MULT;
                end else if (r_bit == '0) begin
                    n_state = B_FIN;
                end
            end
            B_MULT: begin
                if (mac_last) begin
                    n_state = B_CMP;
                end
            end
            B_CMP: begin
                n_state = (r_bit == '0) ? B_FIN : B_SQR;
            end
            B_FIN: begin
                n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // multiply-accumulate steps
    always_ff @(posedge i_clk) begin
        if (mac_state) begin
            if (!mac_last) begin
                r_pp    <= mul_p;
                r_pp_sh <= mul_sh;
            end
            if (r_step != '0) begin
                r_acc <= acc_sum;
            end
            r_step <= r_step + 3'd1;
            if (mac_last) begin
                r_step <= '0;
                r_acc  <= '0;
                case (r_state)
                    B_PROD:  r_p   <= PROD_W'(acc_sum);
                    B_RHS:   r_r   <= PROD_W'(acc_sum);
                    default: r_acc <= acc_sum;
                endcase
            end
        end else if (r_state == B_SQR) begin
            r_t    <= MUL_BW'(mul_p);
            r_step <= '0;
            r_acc  <= '0;
        end else begin
            r_step <= '0;
            r_acc  <= '0;
        end
    end

    // window operands and bit search
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (start) begin
                    r_neg <= i_sums.slr[SLR_W-1];
                    r_mag <= in_mag;
                    r_sll <= i_sums.sll;
                    r_srr <= i_sums.srr;
                    r_q   <= '0;
                    r_bit <= 4'd15;
                end
            end
            B_SQR: begin
                if (cand > Q_W'(32768) && r_bit != '0) begin
                    r_bit <= r_bit - 4'd1;
                end
            end
            B_CMP: begin
                if (r_acc <= {r_r, {MUL_BW{1'b0}}}) begin
                    r_q <= cand;
                end
                if (r_bit != '0) begin
                    r_bit <= r_bit - 4'd1;
                end
            end
            default: begin
                r_bit <= r_bit;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (start && (i_sums.sll == '0 || i_sums.srr == '0)) begin
                r_out_valid <= 1'b1;
            end else if (r_state == B_FIN) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_out <= '0;
        end else if (r_state == B_FIN) begin
            if (r_neg) begin
                r_out <= SAMPLE_W'(Q_W'(0) - r_q);
            end else if (r_q > Q_W'(32767)) begin
                r_out <= SAMPLE_W'(32767);
            end else begin
                r_out <= SAMPLE_W'(r_q);
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_correlation = r_out;

endmodule

[hw/rtl/windowed_stereo_correlation_unit.sv]
// windowed_stereo_correlation_unit: top level with register port, front, queue and back
// depends on wsc_pkg, wsc_front, wsc_queue, wsc_back

// Stereo correlation meter. Each transaction carries one left/right sample pair in
// signed Q1.15; the front end takes one pair per clock unless it holds off input,
// multiplies and accumulates L*R, L*L and R*R, and when window_len pairs have
// arrived it hands the three sums to a two-entry queue and starts a fresh window.
// The back end turns each closed window into one correlation transaction,
// sLR/sqrt(sLL*sRR) in Q1.15 rounded to nearest (+1.0 reads 32767, a zero energy
// reads 0), using one 24x32 multiplier that is time shared: first for the energy
// product and the squared cross sum, then for a square and a product for each of
// the 16 result bits. Input is held off while a window closes on a full queue.
// A trailing partial window never produces a result. window_len sits at byte
// address 0 of the register port, resets to 4800, 0 acts as 1 and values above
// MAX_WINDOW act as MAX_WINDOW; write it only while the block is idle.

module windowed_stereo_correlation_unit #(
    parameter int SAMPLE_BITS = wsc_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_WINDOW  = wsc_pkg::DEF_MAX_WINDOW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [wsc_pkg::SAMPLE_W-1:0] i_left_sample,
    input  logic signed [wsc_pkg::SAMPLE_W-1:0] i_right_sample,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [wsc_pkg::SAMPLE_W-1:0] o_correlation,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wsc_pkg::APB_AW-1:0]          paddr,
    input  logic [wsc_pkg::APB_DW-1:0]          pwdata,
    output logic [wsc_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);
    import wsc_pkg::*;

    logic [WIN_W-1:0] r_window_len;
    logic             push;
    logic             q_not_full;
    logic             q_not_empty;
    logic             pop;
    t_sums            push_sums;
    t_sums            head_sums;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW_LEN) ? APB_DW'(r_window_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_WINDOW_LEN) begin
            r_window_len <= pwdata[WIN_W-1:0];
        end
    end

    // sample intake and accumulation
    wsc_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_window_len   (r_window_len),
        .o_push         (push),
        .o_sums         (push_sums),
        .i_push_ready   (q_not_full)
    );

    // closed windows waiting for the back end
    wsc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_sums      (push_sums),
        .o_not_full  (q_not_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_sums      (head_sums)
    );

    // correlation per window
    wsc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_not_empty   (q_not_empty),
        .i_sums        (head_sums),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_correlation (o_correlation)
    );

endmodule
